// ----- rtl/core/efk_pkg.sv -----
// shared types and constants for the max flow core
package efk_pkg;

  localparam int unsigned FLOW_W   = 22;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VCOUNT_W = 7;
  localparam int unsigned VID_W    = 6;
  localparam int unsigned ECAP_W   = 16;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNSET = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAME  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 2'd2;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

// ----- rtl/core/efk_ram.sv -----
// simple dual port memory with registered read data
module efk_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned W     = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/efk_alu.sv -----
// shared add, subtract and compare unit for residual capacities
module efk_alu #(
  parameter int unsigned W = 17
) (
  input  efk_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     y,
  output logic             lt
);

  always_comb begin
    case (op)
      efk_pkg::ALU_ADD: y = a + b;
      efk_pkg::ALU_SUB: y = a - b;
      default:          y = a;
    endcase
    lt = (a < b);
  end

endmodule

// ----- rtl/core/max_flow_edmonds_karp_core.sv -----
// edmonds-karp max flow core: matrix load, bfs search, bottleneck trace, path augment, residual clear
//
//   channel  dir  ports                                         handshake
//   in       in   row_index col_index edge_capacity last_entry   valid/stall
//   out      out  max_flow status                                valid/stall
//   cfg      in   index data                                     we, no wait
//
// matrix entries are accepted while in_stall is low; the last entry starts
// the search, and the bottleneck trace and the augment then walk the parent
// path, all through one memory port
// after each result and after reset the residual memory is zeroed one entry
// a cycle, all MAX_VERTICES*MAX_VERTICES entries, with in_stall high
// the result waits in an output register until out_stall is low
module max_flow_edmonds_karp_core #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned CAP_BITS     = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [efk_pkg::VID_W-1:0]        in_row_index,
  input  logic [efk_pkg::VID_W-1:0]        in_col_index,
  input  logic [efk_pkg::ECAP_W-1:0]       in_edge_capacity,
  input  logic                             in_last_entry,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [efk_pkg::FLOW_W-1:0]       out_max_flow,
  output logic [efk_pkg::STATUS_W-1:0]     out_status,
  input  logic                             cfg_we,
  input  logic [efk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [efk_pkg::CFG_W-1:0]        cfg_data
);

  localparam int unsigned RW    = CAP_BITS + 1;
  localparam int unsigned DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned VW    = $clog2(MAX_VERTICES);
  localparam int unsigned NW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CW    = (NW > 7) ? NW : 7;
  localparam int unsigned IW    = ((VW > 6) ? VW : 6) + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_INIT, S_POP, S_UPOP, S_SCAN, S_END,
    S_TP, S_TU, S_TC, S_TEND, S_AP, S_AU, S_AF, S_AR, S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [efk_pkg::VCOUNT_W-1:0]  vc_r;
  logic [efk_pkg::VID_W-1:0]     src_r, dst_r;
  logic [AW-1:0]                 clr_r, clr_nxt;
  logic [NW-1:0]                 head_r, head_nxt, tail_r, tail_nxt;
  logic [NW-1:0]                 v_r, v_nxt, steps_r, steps_nxt;
  logic [VW-1:0]                 u_r, u_nxt, vchk_r, vchk_nxt, vx_r, vx_nxt;
  logic                          chk_vld_r, chk_vld_nxt, first_r, first_nxt;
  logic [RW-1:0]                 bott_r, bott_nxt;
  logic [efk_pkg::FLOW_W-1:0]    flow_r, flow_nxt;
  logic [efk_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [MAX_VERTICES-1:0]       visited_r, visited_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [efk_pkg::FLOW_W-1:0]    out_flow_r, out_flow_nxt;
  logic [efk_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;

  logic [CW-1:0]  vc_w, n_w;
  logic [NW-1:0]  n_act;
  logic [VW-1:0]  src_v, dst_v;
  logic [IW-1:0]  row_w, col_w;
  logic           in_acc, row_ok;

  logic           res_we;
  logic [AW-1:0]  res_waddr, res_raddr;
  logic [RW-1:0]  res_wdata, res_rdata;
  logic           par_we;
  logic [VW-1:0]  par_waddr, par_wdata, par_raddr, par_rdata;
  logic           q_we;
  logic [VW-1:0]  q_waddr, q_wdata, q_raddr, q_rdata;

  efk_pkg::alu_op_t alu_op;
  logic [RW-1:0]    alu_y;
  logic             alu_lt;

  efk_ram #(.DEPTH(DEPTH), .W(RW)) u_res (
    .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
    .raddr(res_raddr), .rdata(res_rdata)
  );

  efk_ram #(.DEPTH(MAX_VERTICES), .W(VW)) u_parent (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata)
  );

  efk_ram #(.DEPTH(MAX_VERTICES), .W(VW)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  efk_alu #(.W(RW)) u_alu (
    .op(alu_op), .a(res_rdata), .b(bott_r), .y(alu_y), .lt(alu_lt)
  );

  function automatic logic [AW-1:0] cell_addr(input logic [VW-1:0] r, input logic [VW-1:0] c);
    cell_addr = AW'(r) * AW'(MAX_VERTICES) + AW'(c);
  endfunction

  assign in_stall     = (state_r != S_IDLE);
  assign in_acc       = in_valid && !in_stall;
  assign out_valid    = out_valid_r;
  assign out_max_flow = out_flow_r;
  assign out_status   = out_status_r;

  always_comb begin
    vc_w = CW'(vc_r);
    if (vc_w < CW'(2)) begin
      n_w = CW'(2);
    end else if (vc_w > CW'(MAX_VERTICES)) begin
      n_w = CW'(MAX_VERTICES);
    end else begin
      n_w = vc_w;
    end
    n_act  = NW'(n_w);
    src_v  = VW'(src_r);
    dst_v  = VW'(dst_r);
    row_w  = IW'(in_row_index);
    col_w  = IW'(in_col_index);
    row_ok = (row_w < IW'(MAX_VERTICES)) && (col_w < IW'(MAX_VERTICES));
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    v_nxt          = v_r;
    steps_nxt      = steps_r;
    u_nxt          = u_r;
    vchk_nxt       = vchk_r;
    vx_nxt         = vx_r;
    chk_vld_nxt    = chk_vld_r;
    first_nxt      = first_r;
    bott_nxt       = bott_r;
    flow_nxt       = flow_r;
    status_nxt     = status_r;
    visited_nxt    = visited_r;
    out_valid_nxt  = out_valid_r;
    out_flow_nxt   = out_flow_r;
    out_status_nxt = out_status_r;

    res_we    = 1'b0;
    res_waddr = clr_r;
    res_wdata = '0;
    res_raddr = cell_addr(u_r, VW'(v_r));
    par_we    = 1'b0;
    par_waddr = vchk_r;
    par_wdata = u_r;
    par_raddr = vx_r;
    q_we      = 1'b0;
    q_waddr   = VW'(tail_r);
    q_wdata   = vchk_r;
    q_raddr   = VW'(head_r);
    alu_op    = efk_pkg::ALU_SUB;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        res_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          res_we    = row_ok;
          res_waddr = cell_addr(VW'(row_w), VW'(col_w));
          res_wdata = RW'(CAP_BITS'(in_edge_capacity));
          if (in_last_entry) begin
            flow_nxt = '0;
            if (src_r == '0 || dst_r == '0 || CW'(src_r) >= n_w || CW'(dst_r) >= n_w) begin
              status_nxt = efk_pkg::ST_UNSET;
              state_nxt  = S_DONE;
            end else if (src_r == dst_r) begin
              status_nxt = efk_pkg::ST_SAME;
              state_nxt  = S_DONE;
            end else begin
              status_nxt = efk_pkg::ST_OK;
              state_nxt  = S_INIT;
            end
          end
        end
      end
      S_INIT: begin
        visited_nxt        = '0;
        visited_nxt[src_v] = 1'b1;
        q_we      = 1'b1;
        q_waddr   = '0;
        q_wdata   = src_v;
        par_we    = 1'b1;
        par_waddr = src_v;
        par_wdata = src_v;
        head_nxt  = '0;
        tail_nxt  = NW'(1);
        state_nxt = S_POP;
      end
      S_POP: begin
        state_nxt = (head_r == tail_r) ? S_END : S_UPOP;
      end
      S_UPOP: begin
        u_nxt       = q_rdata;
        head_nxt    = head_r + NW'(1);
        v_nxt       = '0;
        chk_vld_nxt = 1'b0;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        if (v_r < n_act) begin
          v_nxt       = v_r + NW'(1);
          vchk_nxt    = VW'(v_r);
          chk_vld_nxt = 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            state_nxt = S_POP;
          end
        end
        if (chk_vld_r && !visited_r[vchk_r] && res_rdata != '0) begin
          visited_nxt[vchk_r] = 1'b1;
          par_we   = 1'b1;
          q_we     = 1'b1;
          tail_nxt = tail_r + NW'(1);
        end
      end
      S_END: begin
        vx_nxt    = dst_v;
        steps_nxt = '0;
        first_nxt = 1'b1;
        bott_nxt  = '0;
        state_nxt = visited_r[dst_v] ? S_TP : S_DONE;
      end
      S_TP: begin
        state_nxt = (vx_r == src_v || steps_r >= n_act) ? S_TEND : S_TU;
      end
      S_TU: begin
        u_nxt     = par_rdata;
        res_raddr = cell_addr(par_rdata, vx_r);
        state_nxt = S_TC;
      end
      S_TC: begin
        if (first_r || alu_lt) begin
          bott_nxt = res_rdata;
        end
        first_nxt = 1'b0;
        vx_nxt    = u_r;
        steps_nxt = steps_r + NW'(1);
        state_nxt = S_TP;
      end
      S_TEND: begin
        vx_nxt    = dst_v;
        steps_nxt = '0;
        state_nxt = (bott_r == '0) ? S_DONE : S_AP;
      end
      S_AP: begin
        if (vx_r == src_v || steps_r >= n_act) begin
          flow_nxt  = flow_r + efk_pkg::FLOW_W'(bott_r);
          state_nxt = S_INIT;
        end else begin
          state_nxt = S_AU;
        end
      end
      S_AU: begin
        u_nxt     = par_rdata;
        res_raddr = cell_addr(par_rdata, vx_r);
        state_nxt = S_AF;
      end
      S_AF: begin
        alu_op    = efk_pkg::ALU_SUB;
        res_we    = 1'b1;
        res_waddr = cell_addr(u_r, vx_r);
        res_wdata = alu_y;
        res_raddr = cell_addr(vx_r, u_r);
        state_nxt = S_AR;
      end
      S_AR: begin
        alu_op    = efk_pkg::ALU_ADD;
        res_we    = 1'b1;
        res_waddr = cell_addr(vx_r, u_r);
        res_wdata = alu_y;
        vx_nxt    = u_r;
        steps_nxt = steps_r + NW'(1);
        state_nxt = S_AP;
      end
      S_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt  = 1'b1;
          out_flow_nxt   = (status_r == efk_pkg::ST_OK) ? flow_r : '0;
          out_status_nxt = status_r;
          clr_nxt        = '0;
          state_nxt      = S_CLEAR;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      vc_r        <= efk_pkg::VCOUNT_W'(64);
      src_r       <= '0;
      dst_r       <= '0;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      visited_r   <= '0;
      flow_r      <= '0;
      bott_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
      chk_vld_r    <= chk_vld_nxt;
      visited_r    <= visited_nxt;
      flow_r       <= flow_nxt;
      bott_r       <= bott_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      v_r          <= v_nxt;
      steps_r      <= steps_nxt;
      u_r          <= u_nxt;
      vchk_r       <= vchk_nxt;
      vx_r         <= vx_nxt;
      first_r      <= first_nxt;
      status_r     <= status_nxt;
      out_flow_r   <= out_flow_nxt;
      out_status_r <= out_status_nxt;
      if (cfg_we) begin
        case (cfg_index)
          efk_pkg::CFG_VCOUNT: vc_r  <= cfg_data;
          efk_pkg::CFG_SOURCE: src_r <= efk_pkg::VID_W'(cfg_data);
          efk_pkg::CFG_SINK:   dst_r <= efk_pkg::VID_W'(cfg_data);
          default: ;
        endcase
      end
    end
  end

endmodule
